### rtl/header_length_trailer_deframer_defines.svh
// ----------------------------------------------------------------------------
// Deframer assertion macros
// Shared concurrent assertion forms for the deframer RTL.
// ----------------------------------------------------------------------------
`ifndef HEADER_LENGTH_TRAILER_DEFRAMER_DEFINES_SVH
`define HEADER_LENGTH_TRAILER_DEFRAMER_DEFINES_SVH

// condition must hold at every edge outside reset
`define HLTD_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("deframer assertion failed");

// consequent must hold in the same cycle as the antecedent
`define HLTD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

`endif

### rtl/hltd_pkg.sv
// ----------------------------------------------------------------------------
// Deframer package
// Types, phase and event codes and register indices for the deframer.
// ----------------------------------------------------------------------------
package hltd_pkg;

   localparam int PH_W    = 3;
   localparam int EVENT_W = 3;
   localparam int CNT_W   = 3;
   localparam int SIZE_W  = 32;
   localparam int MAX_W   = 25;
   localparam int PAT_W   = 64;
   localparam int PERM_W  = 8;
   localparam int IDX_W   = 2;

   localparam logic [PH_W-1:0] PH_HUNT    = 3'd0;
   localparam logic [PH_W-1:0] PH_SIZE    = 3'd1;
   localparam logic [PH_W-1:0] PH_CHECK   = 3'd2;
   localparam logic [PH_W-1:0] PH_PAYLOAD = 3'd3;
   localparam logic [PH_W-1:0] PH_TRAILER = 3'd4;

   localparam logic [EVENT_W-1:0] EV_DATA      = 3'd0;
   localparam logic [EVENT_W-1:0] EV_OK        = 3'd1;
   localparam logic [EVENT_W-1:0] EV_TOO_BIG   = 3'd2;
   localparam logic [EVENT_W-1:0] EV_CHECK_BAD = 3'd3;
   localparam logic [EVENT_W-1:0] EV_TRL_BAD   = 3'd4;

   localparam logic [IDX_W-1:0] CSR_HEADER  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_TRAILER = 2'd1;
   localparam logic [IDX_W-1:0] CSR_PERM    = 2'd2;
   localparam logic [IDX_W-1:0] CSR_MAX     = 2'd3;

   localparam logic [PERM_W-1:0] PERM_RESET = 8'd228;
   localparam logic [MAX_W-1:0]  MAX_RESET  = 25'd65536;

   localparam logic [CNT_W-1:0] LAST_SIZE_CNT = 3'd3;

   typedef struct packed {
      logic [PAT_W-1:0]  header_pattern;
      logic [PAT_W-1:0]  trailer_pattern;
      logic [PERM_W-1:0] size_permutation;
      logic [MAX_W-1:0]  max_frame_bytes;
   } cfg_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_kind;
      logic [7:0]         payload_byte;
      logic               payload_last;
   } rsp_type;

endpackage

### rtl/hltd_csr.sv
// ----------------------------------------------------------------------------
// Deframer configuration registers
// Header/trailer patterns, size permutation and frame size limit.
// ----------------------------------------------------------------------------
module hltd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [hltd_pkg::IDX_W-1:0]  csr_index,
   input  logic [hltd_pkg::PAT_W-1:0]  csr_wr_data,
   output hltd_pkg::cfg_type           cfg_o
);

   hltd_pkg::cfg_type cfg_ff;
   hltd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            hltd_pkg::CSR_HEADER:  cfg_in.header_pattern   = csr_wr_data;
            hltd_pkg::CSR_TRAILER: cfg_in.trailer_pattern  = csr_wr_data;
            hltd_pkg::CSR_PERM:
               cfg_in.size_permutation = csr_wr_data[hltd_pkg::PERM_W-1:0];
            hltd_pkg::CSR_MAX:
               cfg_in.max_frame_bytes  = csr_wr_data[hltd_pkg::MAX_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_pattern   <= '0;
         cfg_ff.trailer_pattern  <= '0;
         cfg_ff.size_permutation <= hltd_pkg::PERM_RESET;
         cfg_ff.max_frame_bytes  <= hltd_pkg::MAX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_o = cfg_ff;

endmodule

### rtl/hltd_fsm.sv
// ----------------------------------------------------------------------------
// Deframer frame state machine
// Consumes one byte per transfer and decides the result it raises, if any.
// ----------------------------------------------------------------------------
`include "header_length_trailer_deframer_defines.svh"

module hltd_fsm #(
   parameter int HDR_LEN = 4,
   parameter int TRL_LEN = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  hltd_pkg::cfg_type  cfg_i,
   input  logic               byte_xfer_i,
   input  logic [7:0]         rx_byte_i,
   output logic               push_o,
   output hltd_pkg::rsp_type  rsp_o
);

   logic [hltd_pkg::PH_W-1:0]   phase_ff, phase_in;
   logic [hltd_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [hltd_pkg::SIZE_W-1:0] left_ff, left_in;
   logic                        tgood_ff, tgood_in;
   logic [7:0]                  size_ff [4];
   logic [7:0]                  check_ff [4];
   logic [7:0]                  chk [4];
   logic [hltd_pkg::SIZE_W-1:0] size_word;
   logic [hltd_pkg::SIZE_W-1:0] stored_size;
   logic                        mismatch;
   logic                        last;
   logic                        tbyte_ok;
   logic [7:0]                  hdr_byte;
   logic [7:0]                  trl_byte;
   logic                        size_wr;
   logic                        check_wr;

   assign hdr_byte = cfg_i.header_pattern[{cnt_ff, 3'b000} +: 8];
   assign trl_byte = cfg_i.trailer_pattern[{cnt_ff, 3'b000} +: 8];
   assign size_word = {rx_byte_i, size_ff[2], size_ff[1], size_ff[0]};
   assign stored_size = {size_ff[3], size_ff[2], size_ff[1], size_ff[0]};
   assign last = (left_ff <= hltd_pkg::SIZE_W'(1));
   assign tbyte_ok = (rx_byte_i == trl_byte);

   always_comb begin
      chk[0] = check_ff[0];
      chk[1] = check_ff[1];
      chk[2] = check_ff[2];
      chk[3] = rx_byte_i;
      mismatch = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (chk[cfg_i.size_permutation[2*i +: 2]] != size_ff[i]) begin
            mismatch = 1'b1;
         end
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      tgood_in = tgood_ff;
      push_o   = 1'b0;
      size_wr  = 1'b0;
      check_wr = 1'b0;
      rsp_o    = '{event_kind: hltd_pkg::EV_DATA, payload_byte: 8'd0, payload_last: 1'b0};
      if (byte_xfer_i) begin
         case (phase_ff)
            hltd_pkg::PH_SIZE: begin
               size_wr = 1'b1;
               if (cnt_ff == hltd_pkg::LAST_SIZE_CNT) begin
                  cnt_in = '0;
                  if (size_word >= {{(hltd_pkg::SIZE_W-hltd_pkg::MAX_W){1'b0}},
                                    cfg_i.max_frame_bytes}) begin
                     phase_in = hltd_pkg::PH_HUNT;
                     push_o   = 1'b1;
                     rsp_o.event_kind = hltd_pkg::EV_TOO_BIG;
                  end else begin
                     phase_in = hltd_pkg::PH_CHECK;
                  end
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            hltd_pkg::PH_CHECK: begin
               check_wr = 1'b1;
               if (cnt_ff == hltd_pkg::LAST_SIZE_CNT) begin
                  cnt_in = '0;
                  if (mismatch) begin
                     phase_in = hltd_pkg::PH_HUNT;
                     push_o   = 1'b1;
                     rsp_o.event_kind = hltd_pkg::EV_CHECK_BAD;
                  end else begin
                     left_in  = stored_size;
                     tgood_in = 1'b1;
                     phase_in = (stored_size == '0) ? hltd_pkg::PH_TRAILER
                                                    : hltd_pkg::PH_PAYLOAD;
                  end
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            hltd_pkg::PH_PAYLOAD: begin
               push_o = 1'b1;
               rsp_o.payload_byte = rx_byte_i;
               rsp_o.payload_last = last;
               if (last) begin
                  left_in  = '0;
                  phase_in = hltd_pkg::PH_TRAILER;
                  cnt_in   = '0;
                  tgood_in = 1'b1;
               end else begin
                  left_in = left_ff - 1'b1;
               end
            end
            hltd_pkg::PH_TRAILER: begin
               if (cnt_ff == hltd_pkg::CNT_W'(TRL_LEN - 1)) begin
                  push_o   = 1'b1;
                  rsp_o.event_kind = (tgood_ff && tbyte_ok) ? hltd_pkg::EV_OK
                                                            : hltd_pkg::EV_TRL_BAD;
                  cnt_in   = '0;
                  tgood_in = 1'b1;
                  phase_in = hltd_pkg::PH_HUNT;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  tgood_in = tgood_ff && tbyte_ok;
               end
            end
            default: begin
               phase_in = hltd_pkg::PH_HUNT;
               if (rx_byte_i == hdr_byte) begin
                  if (cnt_ff == hltd_pkg::CNT_W'(HDR_LEN - 1)) begin
                     cnt_in   = '0;
                     phase_in = hltd_pkg::PH_SIZE;
                  end else begin
                     cnt_in = cnt_ff + 1'b1;
                  end
               end else begin
                  cnt_in = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= hltd_pkg::PH_HUNT;
         cnt_ff   <= '0;
         left_ff  <= '0;
         tgood_ff <= 1'b1;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         tgood_ff <= tgood_in;
      end
   end

   // size and check stores are always written before they are read
   always_ff @(posedge clock) begin
      if (size_wr) begin
         size_ff[cnt_ff[1:0]] <= rx_byte_i;
      end
      if (check_wr) begin
         check_ff[cnt_ff[1:0]] <= rx_byte_i;
      end
   end

   `HLTD_ASSERT_IMPLY(a_gather_cnt, clock, reset, (phase_ff == hltd_pkg::PH_SIZE || phase_ff == hltd_pkg::PH_CHECK), (cnt_ff <= hltd_pkg::LAST_SIZE_CNT))
   `HLTD_ASSERT_IMPLY(a_event_clean, clock, reset, (push_o && rsp_o.event_kind != hltd_pkg::EV_DATA), (rsp_o.payload_byte == 8'd0 && !rsp_o.payload_last))
   `HLTD_ASSERT_IMPLY(a_payload_left, clock, reset, (phase_ff == hltd_pkg::PH_PAYLOAD), (left_ff != '0))

endmodule

### rtl/hltd_out.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Output register plus skid stage so a byte can transfer while a result waits.
// ----------------------------------------------------------------------------
`include "header_length_trailer_deframer_defines.svh"

module hltd_out (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_i,
   input  hltd_pkg::rsp_type  rsp_i,
   output logic               space_o,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hltd_pkg::rsp_type  rsp_o
);

   logic              main_vld_ff, main_vld_in;
   logic              skid_vld_ff, skid_vld_in;
   hltd_pkg::rsp_type main_ff, main_in;
   hltd_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign pop = main_vld_ff && rsp_ready;

   always_comb begin
      main_vld_in = main_vld_ff;
      skid_vld_in = skid_vld_ff;
      main_in     = main_ff;
      skid_in     = skid_ff;
      if (skid_vld_ff) begin
         if (pop) begin
            main_in     = skid_ff;
            skid_vld_in = 1'b0;
         end
      end else if (push_i) begin
         if (!main_vld_ff || pop) begin
            main_in     = rsp_i;
            main_vld_in = 1'b1;
         end else begin
            skid_in     = rsp_i;
            skid_vld_in = 1'b1;
         end
      end else if (pop) begin
         main_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign space_o   = !skid_vld_ff;
   assign rsp_valid = main_vld_ff;
   assign rsp_o     = main_ff;

   `HLTD_ASSERT_IMPLY(a_skid_behind_main, clock, reset, skid_vld_ff, main_vld_ff)
   `HLTD_ASSERT_IMPLY(a_no_push_when_full, clock, reset, skid_vld_ff, !push_i)

endmodule

### rtl/header_length_trailer_deframer.sv
// A byte transfer's result is registered in the output register, or in the skid stage
// if that register holds one not yet taken, and is shown on rsp_*. One byte per cycle
// while req_ready is high; a two-deep result register keeps req_ready high while one
// result waits. Reset (synchronous, active high) returns to header hunting, clears
// counts, sets tgood_ff, loads config reset values and empties the result register.
// ----------------------------------------------------------------------------
// Header/length/trailer deframer
// Hunts for a header, reads and cross-checks a 4-byte size, forwards the
// payload and verifies the trailer.
// ----------------------------------------------------------------------------
module header_length_trailer_deframer #(
   parameter int HDR_LEN = 4,
   parameter int TRL_LEN = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hltd_pkg::EVENT_W-1:0]  rsp_event_kind,
   output logic [7:0]                    rsp_payload_byte,
   output logic                          rsp_payload_last,
   input  logic                          csr_wr_en,
   input  logic [hltd_pkg::IDX_W-1:0]    csr_index,
   input  logic [hltd_pkg::PAT_W-1:0]    csr_wr_data
);

   hltd_pkg::cfg_type cfg;
   hltd_pkg::rsp_type fsm_rsp;
   hltd_pkg::rsp_type out_rsp;
   logic              push;
   logic              space;
   logic              byte_xfer;

   assign req_ready = space;
   assign byte_xfer = req_valid && space;

   hltd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg_o       (cfg)
   );

   hltd_fsm #(
      .HDR_LEN (HDR_LEN),
      .TRL_LEN (TRL_LEN)
   ) u_fsm (
      .clock       (clock),
      .reset       (reset),
      .cfg_i       (cfg),
      .byte_xfer_i (byte_xfer),
      .rx_byte_i   (req_rx_byte),
      .push_o      (push),
      .rsp_o       (fsm_rsp)
   );

   hltd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push_i    (push),
      .rsp_i     (fsm_rsp),
      .space_o   (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_o     (out_rsp)
   );

   assign rsp_event_kind   = out_rsp.event_kind;
   assign rsp_payload_byte = out_rsp.payload_byte;
   assign rsp_payload_last = out_rsp.payload_last;

endmodule
